@@ hdl/aoc_pkg.sv @@
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared constants, opcodes and controller/datapath bundles for the
// AABB obstacle overlap checker.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int FIELD_BITS        = 32;
    localparam int OPCODE_BITS       = 2;
    localparam int AXES              = 3;
    localparam int BOUNDS            = 2 * AXES;
    localparam int MAX_OBSTACLES_DEF = 64;
    localparam int COORD_BITS_DEF    = 32;

    localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_TEST   = 2'd2;

    typedef struct packed {
        logic load_box;
        logic mem_we;
        logic mem_re;
        logic hit_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_valid;
        logic hit;
    } dp_status_t;

    function automatic int idx_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ hdl/aoc_ifs.sv @@
// ----------------------------------------------------------------------------
// aoc_ifs
// Valid/ready channels: box request stream and query result stream.
// ----------------------------------------------------------------------------
interface aoc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [aoc_pkg::OPCODE_BITS-1:0]       opcode;
    logic signed [aoc_pkg::FIELD_BITS-1:0] min_x;
    logic signed [aoc_pkg::FIELD_BITS-1:0] min_y;
    logic signed [aoc_pkg::FIELD_BITS-1:0] min_z;
    logic signed [aoc_pkg::FIELD_BITS-1:0] max_x;
    logic signed [aoc_pkg::FIELD_BITS-1:0] max_y;
    logic signed [aoc_pkg::FIELD_BITS-1:0] max_z;
    logic                                  final_box;

    modport source (output valid, opcode, min_x, min_y, min_z, max_x, max_y, max_z,
                    final_box, input ready);
    modport sink   (input valid, opcode, min_x, min_y, min_z, max_x, max_y, max_z,
                    final_box, output ready);
endinterface

interface aoc_rsp_if;
    logic valid;
    logic ready;
    logic collides;
    logic table_overflowed;

    modport source (output valid, collides, table_overflowed, input ready);
    modport sink   (input valid, collides, table_overflowed, output ready);
endinterface

@@ hdl/aoc_datapath.sv @@
// ----------------------------------------------------------------------------
// aoc_datapath
// Obstacle table memory, link box register and per-axis overlap compare
// with hit accumulator.
// ----------------------------------------------------------------------------
module aoc_datapath #(
    parameter int MAX_OBSTACLES = aoc_pkg::MAX_OBSTACLES_DEF,
    parameter int COORD_BITS    = aoc_pkg::COORD_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          min_x,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          min_y,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          min_z,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          max_x,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          max_y,
    input  logic signed [aoc_pkg::FIELD_BITS-1:0]          max_z,
    input  aoc_pkg::dp_cmd_t                               cmd,
    input  logic [aoc_pkg::idx_bits(MAX_OBSTACLES)-1:0]    waddr,
    input  logic [aoc_pkg::idx_bits(MAX_OBSTACLES)-1:0]    raddr,
    output aoc_pkg::dp_status_t                            status
);

    localparam int WORD_BITS = aoc_pkg::BOUNDS * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic [aoc_pkg::FIELD_BITS-1:0] raw [aoc_pkg::BOUNDS];
    coord_t                         in_c [aoc_pkg::BOUNDS];
    coord_t                         box_reg [aoc_pkg::BOUNDS];
    coord_t                         obs [aoc_pkg::BOUNDS];
    logic [WORD_BITS-1:0]           in_word;
    logic [WORD_BITS-1:0]           mem [MAX_OBSTACLES];
    logic [WORD_BITS-1:0]           rdata_reg;
    logic                           rd_valid_reg;
    logic                           hit_reg;
    logic                           overlap;

    assign raw[0] = min_x;
    assign raw[1] = min_y;
    assign raw[2] = min_z;
    assign raw[3] = max_x;
    assign raw[4] = max_y;
    assign raw[5] = max_z;

    for (genvar k = 0; k < aoc_pkg::BOUNDS; k++) begin : g_coord
        if (COORD_BITS <= aoc_pkg::FIELD_BITS) begin : g_narrow
            assign in_c[k] = raw[k][COORD_BITS-1:0];
        end
        else begin : g_wide
            assign in_c[k] = {{(COORD_BITS - aoc_pkg::FIELD_BITS){1'b0}}, raw[k]};
        end
        assign in_word[k*COORD_BITS +: COORD_BITS] = in_c[k];
        assign obs[k] = rdata_reg[k*COORD_BITS +: COORD_BITS];
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[waddr] <= in_word;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_box)
        begin
            box_reg <= in_c;
        end
    end

    // touching counts as overlap
    always_comb
    begin
        overlap = 1'b1;
        for (int a = 0; a < aoc_pkg::AXES; a++)
        begin
            if (box_reg[a+aoc_pkg::AXES] < obs[a] || box_reg[a] > obs[a+aoc_pkg::AXES])
            begin
                overlap = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.mem_re;
            if (cmd.hit_clr)
            begin
                hit_reg <= 1'b0;
            end
            else if (rd_valid_reg && overlap)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    assign status.rd_valid = rd_valid_reg;
    assign status.hit      = hit_reg;

endmodule

@@ hdl/aoc_controller.sv @@
// ----------------------------------------------------------------------------
// aoc_controller
// Request decode, obstacle fill count, table scan sequencing and result
// output register.
// ----------------------------------------------------------------------------
module aoc_controller #(
    parameter int MAX_OBSTACLES = aoc_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    aoc_req_if.sink                                        req,
    aoc_rsp_if.source                                      rsp,
    output aoc_pkg::dp_cmd_t                               cmd,
    output logic [aoc_pkg::idx_bits(MAX_OBSTACLES)-1:0]    waddr,
    output logic [aoc_pkg::idx_bits(MAX_OBSTACLES)-1:0]    raddr,
    input  aoc_pkg::dp_status_t                            status
);

    localparam int IDX_W = aoc_pkg::idx_bits(MAX_OBSTACLES);
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSTACLES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             final_reg;
    logic             overflow_reg;
    logic             out_valid_reg;
    logic             collides_reg;
    logic             overflowed_reg;

    logic accept;
    logic out_free;
    logic issue_more;
    logic scan_done;
    logic has_room;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign issue_more = issue_reg < count_reg;
    assign scan_done  = !issue_more && !status.rd_valid;
    assign has_room   = count_reg < CNT_MAX;

    assign waddr = count_reg[IDX_W-1:0];
    assign raddr = issue_reg[IDX_W-1:0];

    always_comb
    begin
        cmd          = '0;
        cmd.load_box = accept && (req.opcode == aoc_pkg::OP_TEST);
        cmd.mem_we   = accept && (req.opcode == aoc_pkg::OP_APPEND) && has_room;
        cmd.mem_re   = (state_reg == S_SCAN) && issue_more;
        cmd.hit_clr  = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            final_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            collides_reg   <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.opcode)
                            aoc_pkg::OP_CLEAR:
                            begin
                                count_reg    <= '0;
                                overflow_reg <= 1'b0;
                            end
                            aoc_pkg::OP_APPEND:
                            begin
                                if (has_room)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            aoc_pkg::OP_TEST:
                            begin
                                final_reg <= req.final_box;
                                issue_reg <= '0;
                                if (count_reg != '0)
                                begin
                                    state_reg <= S_SCAN;
                                end
                                else if (req.final_box)
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= final_reg ? S_FINISH : S_IDLE;
                    end
                    else if (issue_more)
                    begin
                        issue_reg <= issue_reg + CNT_W'(1);
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        collides_reg   <= status.hit;
                        overflowed_reg <= overflow_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.collides         = collides_reg;
    assign rsp.table_overflowed = overflowed_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("obstacle count beyond table depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == aoc_pkg::OP_CLEAR |=> count_reg == '0)
        else $error("clear did not empty the table");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> issue_reg <= count_reg)
        else $error("scan ran past filled entries");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && out_free |=> rsp.valid && state_reg == S_IDLE)
        else $error("result not presented after finish");

endmodule

@@ hdl/aabb_obstacle_overlap_checker.sv @@
// ----------------------------------------------------------------------------
// aabb_obstacle_overlap_checker
// 3D axis-aligned box overlap test of link boxes against a stored obstacle
// table, one result per query.
// ----------------------------------------------------------------------------
// A link box is compared against the stored obstacles one table read per
// cycle, and it occupies the block until its scan is done; the final box of
// a query also loads the result register. With an empty table no reads are
// made. The table memory's single read port sets this rate. The result
// register lets a new request be taken while a result waits on rsp. Touching
// boxes count as overlapping. Appends to a full table are dropped and
// flagged until the next clear.
module aabb_obstacle_overlap_checker #(
    parameter int MAX_OBSTACLES = aoc_pkg::MAX_OBSTACLES_DEF,
    parameter int COORD_BITS    = aoc_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    aoc_req_if.sink    req,
    aoc_rsp_if.source  rsp
);

    localparam int IDX_W = aoc_pkg::idx_bits(MAX_OBSTACLES);

    aoc_pkg::dp_cmd_t    cmd;
    aoc_pkg::dp_status_t status;
    logic [IDX_W-1:0]    waddr;
    logic [IDX_W-1:0]    raddr;

    aoc_controller #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .waddr  (waddr),
        .raddr  (raddr),
        .status (status)
    );

    aoc_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .min_x  (req.min_x),
        .min_y  (req.min_y),
        .min_z  (req.min_z),
        .max_x  (req.max_x),
        .max_y  (req.max_y),
        .max_z  (req.max_z),
        .cmd    (cmd),
        .waddr  (waddr),
        .raddr  (raddr),
        .status (status)
    );

endmodule
